// ===== rtl/rls_pkg.sv =====
// rls_pkg: shared types and constants for the ranked list store.
// Operation and status codes, port widths, default sizes, cell control struct.
// No dependencies.
`default_nettype none

package rls_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int ELEM_WIDTH_DEF = 32;

  localparam int KIND_W   = 3;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int SIZE_W   = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_GET    = 3'd2,
    KIND_SET    = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANK  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Broadcast to every cell in the cycle an operation is accepted.
  typedef struct packed {
    logic ins_go;
    logic rem_go;
    logic set_go;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rls_cell.sv =====
// rls_cell: one entry of the ranked list store.
// Holds one value and shifts it to/from its neighbors on insert/remove.
// Depends on rls_pkg.
`default_nettype none

module rls_cell #(
  parameter int IDX        = 0,
  parameter int ELEM_WIDTH = rls_pkg::ELEM_WIDTH_DEF,
  parameter int CMP_W      = rls_pkg::RANK_W
) (
  input  wire logic                  clk,
  input  wire rls_pkg::cell_ctl_t    ctl,
  input  wire logic [CMP_W-1:0]      rank,
  input  wire logic [ELEM_WIDTH-1:0] wr_val,
  input  wire logic [ELEM_WIDTH-1:0] lower_val,
  input  wire logic [ELEM_WIDTH-1:0] upper_val,
  output logic      [ELEM_WIDTH-1:0] val,
  output logic      [ELEM_WIDTH-1:0] rd_val
);

  logic [ELEM_WIDTH-1:0] val_r;
  logic [ELEM_WIDTH-1:0] val_nxt;
  logic                  at;
  logic                  above;

  assign at    = (rank == CMP_W'(IDX));
  assign above = (rank < CMP_W'(IDX));

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_go) begin
      if (above) begin
        val_nxt = lower_val;
      end else if (at) begin
        val_nxt = wr_val;
      end
    end else if (ctl.rem_go) begin
      if (above || at) begin
        val_nxt = upper_val;
      end
    end else if (ctl.set_go && at) begin
      val_nxt = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val    = val_r;
  // Only the addressed cell drives the read bus; the rest contribute zero.
  assign rd_val = at ? val_r : '0;

endmodule

`default_nettype wire

// ===== rtl/ranked_list_store.sv =====
// ranked_list_store: bounded ordered list addressed by rank, top level.
// Instantiates a row of rls_cell entries; uses rls_pkg.
//
// One operation is taken per start pulse; busy stays low, so a new operation may
// be issued every cycle. All entries sit in a row of cells that shift in parallel,
// so insert and remove finish in the same cycle they are accepted. The result
// (status, old/read value, size after the operation) is shown for exactly one cycle
// on out_valid, in the cycle after the transfer, and cannot be held off. Throughput is
// one operation per cycle, set by the parallel cell shift and the rank-addressed
// read over all cells.
`default_nettype none

module ranked_list_store #(
  parameter int CAPACITY   = rls_pkg::CAPACITY_DEF,
  parameter int ELEM_WIDTH = rls_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [rls_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [rls_pkg::RANK_W-1:0]    in_rank,
  input  wire logic [rls_pkg::VALUE_W-1:0]   in_elem_value,
  output logic                               out_valid,
  output logic [rls_pkg::STATUS_W-1:0]       out_status,
  output logic [rls_pkg::VALUE_W-1:0]        out_elem_out,
  output logic [rls_pkg::SIZE_W-1:0]         out_current_size
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > rls_pkg::RANK_W) ? CNT_W : rls_pkg::RANK_W;

  logic                   accept;
  logic [CNT_W-1:0]       cnt_r;
  logic [CNT_W-1:0]       cnt_nxt;
  logic [CMP_W-1:0]       rank_x;
  logic [CMP_W-1:0]       cnt_x;
  logic [63:0]            in_wide;
  logic [ELEM_WIDTH-1:0]  wr_val;
  logic [ELEM_WIDTH-1:0]  rd_val;
  logic [63:0]            rd_wide;
  rls_pkg::cell_ctl_t     ctl;
  rls_pkg::status_t       status;
  logic                   use_rd;

  logic                   out_valid_r;
  logic [rls_pkg::STATUS_W-1:0] out_status_r;
  logic [rls_pkg::VALUE_W-1:0]  out_elem_out_r;

  logic [ELEM_WIDTH-1:0]  cell_val [CAPACITY];
  logic [ELEM_WIDTH-1:0]  cell_rd  [CAPACITY];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign rank_x  = CMP_W'(in_rank);
  assign cnt_x   = CMP_W'(cnt_r);
  assign in_wide = 64'(in_elem_value);
  assign wr_val  = in_wide[ELEM_WIDTH-1:0];

  // Decode
  always_comb begin
    ctl     = '0;
    status  = rls_pkg::ST_OK;
    use_rd  = 1'b0;
    cnt_nxt = cnt_r;
    unique case (in_kind)
      rls_pkg::KIND_INSERT: begin
        if (rank_x > cnt_x) begin
          status = rls_pkg::ST_RANK;
        end else if (cnt_x == CMP_W'(CAPACITY)) begin
          status = rls_pkg::ST_FULL;
        end else begin
          ctl.ins_go = accept;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
      end
      rls_pkg::KIND_REMOVE: begin
        if (cnt_r == '0) begin
          status = rls_pkg::ST_EMPTY;
        end else if (rank_x >= cnt_x) begin
          status = rls_pkg::ST_RANK;
        end else begin
          ctl.rem_go = accept;
          use_rd     = 1'b1;
          cnt_nxt    = cnt_r - CNT_W'(1);
        end
      end
      rls_pkg::KIND_GET: begin
        if (rank_x >= cnt_x) begin
          status = rls_pkg::ST_RANK;
        end else begin
          use_rd = 1'b1;
        end
      end
      rls_pkg::KIND_SET: begin
        if (rank_x >= cnt_x) begin
          status = rls_pkg::ST_RANK;
        end else begin
          ctl.set_go = accept;
          use_rd     = 1'b1;
        end
      end
      rls_pkg::KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        status = rls_pkg::ST_RANK;
      end
    endcase
  end

  // Cell row
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lower;
    logic [ELEM_WIDTH-1:0] upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = cell_val[g];
    end else begin : g_mid_hi
      assign upper = cell_val[g+1];
    end
    rls_cell #(
      .IDX        (g),
      .ELEM_WIDTH (ELEM_WIDTH),
      .CMP_W      (CMP_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .rank      (rank_x),
      .wr_val    (wr_val),
      .lower_val (lower),
      .upper_val (upper),
      .val       (cell_val[g]),
      .rd_val    (cell_rd[g])
    );
  end

  // At most one cell hits, so OR-ing the read contributions selects it.
  always_comb begin
    rd_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_val = rd_val | cell_rd[i];
    end
  end

  assign rd_wide = 64'(rd_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r   <= status;
      out_elem_out_r <= use_rd ? rd_wide[rls_pkg::VALUE_W-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_elem_out     = out_elem_out_r;
  assign out_current_size = rls_pkg::SIZE_W'(cnt_r);

  // Checks
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("no result after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rls_pkg::ST_OK) |-> out_elem_out == '0)
    else $error("nonzero value on error result");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == rls_pkg::KIND_INSERT && status == rls_pkg::ST_OK)
    |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("insert did not grow list");

endmodule

`default_nettype wire
